// ----- rtl/julia_escape_time_pixel_core_macros.svh -----
// Assertion macros for the escape-time pixel core port-level checker
`ifndef JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH
`define JULIA_ESCAPE_TIME_PIXEL_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, idle during reset
`define JET_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock, idle during reset
`define JET_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/jet_pkg.sv -----
// Shared types, constants and helper functions for the escape-time pixel core
`timescale 1ns / 1ps

package jet_pkg;

   // Field widths
   localparam int Q_WIDTH      = 32;
   localparam int COORD_WIDTH  = 12;
   localparam int LIMIT_WIDTH  = 16;
   localparam int IMGW_WIDTH   = 13;
   localparam int ADDR_WIDTH   = 24;
   localparam int PAL_WIDTH    = 8;
   localparam int CSR_IDX_WIDTH = 3;

   // Block constants
   localparam int PALETTE_ENTRIES = 8;
   localparam int MAX_DIMENSION   = 4096;
   localparam int Q_FRAC          = 28;

   // Escape radius squared, 4.0 in Q8.56
   localparam logic [63:0] ESCAPE_Q56 = 64'h0400_0000_0000_0000;

   // Register reset values
   localparam logic signed [31:0] ORIGIN_X_RESET = -32'sd536870912;
   localparam logic signed [31:0] ORIGIN_Y_RESET = -32'sd536870912;
   localparam logic signed [31:0] STEP_X_RESET   = 32'sd1048576;
   localparam logic signed [31:0] STEP_Y_RESET   = 32'sd1048576;
   localparam logic signed [31:0] C_REAL_RESET   = -32'sd214748365;
   localparam logic signed [31:0] C_IMAG_RESET   = 32'sd0;
   localparam logic [15:0]        LIMIT_RESET    = 16'd256;
   localparam logic [12:0]        IMGW_RESET     = 13'd1024;

   // Register map
   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_STEP_X     = 3'd2,
      CSR_STEP_Y     = 3'd3,
      CSR_C_REAL     = 3'd4,
      CSR_C_IMAG     = 3'd5,
      CSR_ITER_LIMIT = 3'd6,
      CSR_IMAGE_WIDTH = 3'd7
   } csr_index_type;

   // Operand selection for the shared multiplier
   typedef enum logic [1:0] {
      MUL_RR = 2'd0,
      MUL_II = 2'd1,
      MUL_RI = 2'd2
   } mul_sel_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE   = 4'd0,
      ST_START  = 4'd1,
      ST_SQR0   = 4'd2,
      ST_SQI0   = 4'd3,
      ST_CROSS  = 4'd4,
      ST_UPDATE = 4'd5,
      ST_SQR    = 4'd6,
      ST_SQI    = 4'd7,
      ST_TEST   = 4'd8,
      ST_FINISH = 4'd9
   } state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic        load_pixel;
      logic        start;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        update;
      logic        count_inc;
      logic        load_result;
   } jet_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic start_in_set;
      logic escaped;
      logic limit_next;
   } jet_status_type;

   // Saturate a wide signed value to Q4.28
   function automatic logic signed [31:0] sat_q(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Pin a pixel index to the largest supported dimension
   function automatic logic [COORD_WIDTH-1:0] clamp_dim(input logic [COORD_WIDTH-1:0] v);
      logic [COORD_WIDTH-1:0] r;
      if ({1'b0, v} >= (COORD_WIDTH+1)'(MAX_DIMENSION)) begin
         r = COORD_WIDTH'(MAX_DIMENSION - 1);
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// ----- rtl/jet_datapath.sv -----
// Datapath: configuration registers, start point, shared multiplier, z update, result
`timescale 1ns / 1ps

module jet_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [jet_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [31:0]                  csr_wdata,
   input  logic [jet_pkg::COORD_WIDTH-1:0] pix_column,
   input  logic [jet_pkg::COORD_WIDTH-1:0] pix_row,
   input  jet_pkg::jet_cmd_type         cmd,
   output jet_pkg::jet_status_type      status,
   output logic [jet_pkg::ADDR_WIDTH-1:0]  res_address,
   output logic [jet_pkg::LIMIT_WIDTH-1:0] res_count,
   output logic                         res_in_set,
   output logic [jet_pkg::PAL_WIDTH-1:0]   res_palette
);

   logic signed [31:0] origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic signed [31:0] step_x_ff, step_x_in, step_y_ff, step_y_in;
   logic signed [31:0] c_real_ff, c_real_in, c_imag_ff, c_imag_in;
   logic [15:0]        limit_ff, limit_in;
   logic [12:0]        imgw_ff, imgw_in;

   logic [11:0]        col_ff, col_in, row_ff, row_in;
   logic signed [31:0] zr_ff, zr_in, zi_ff, zi_in;
   logic signed [63:0] rr_ff, rr_in, ii_ff, ii_in, ri_ff, ri_in;
   logic [15:0]        count_ff, count_in;
   logic [23:0]        addr_ff, addr_in;

   logic [23:0]        res_addr_ff, res_addr_in;
   logic [15:0]        res_count_ff, res_count_in;
   logic               res_in_set_ff, res_in_set_in;
   logic [7:0]         res_pal_ff, res_pal_in;

   logic signed [44:0] prod_x, prod_y;
   logic signed [45:0] sum_x, sum_y;
   logic [25:0]        addr_full;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] diff;
   logic signed [39:0] upd_r, upd_i;
   logic [63:0]        mag;
   logic               at_limit;

   // Configuration writes
   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      step_x_in   = step_x_ff;
      step_y_in   = step_y_ff;
      c_real_in   = c_real_ff;
      c_imag_in   = c_imag_ff;
      limit_in    = limit_ff;
      imgw_in     = imgw_ff;
      if (csr_we) begin
         case (csr_index)
            jet_pkg::CSR_ORIGIN_X:    origin_x_in = $signed(csr_wdata);
            jet_pkg::CSR_ORIGIN_Y:    origin_y_in = $signed(csr_wdata);
            jet_pkg::CSR_STEP_X:      step_x_in   = $signed(csr_wdata);
            jet_pkg::CSR_STEP_Y:      step_y_in   = $signed(csr_wdata);
            jet_pkg::CSR_C_REAL:      c_real_in   = $signed(csr_wdata);
            jet_pkg::CSR_C_IMAG:      c_imag_in   = $signed(csr_wdata);
            jet_pkg::CSR_ITER_LIMIT:  limit_in    = csr_wdata[15:0];
            jet_pkg::CSR_IMAGE_WIDTH: imgw_in     = csr_wdata[12:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= jet_pkg::ORIGIN_X_RESET;
         origin_y_ff <= jet_pkg::ORIGIN_Y_RESET;
         step_x_ff   <= jet_pkg::STEP_X_RESET;
         step_y_ff   <= jet_pkg::STEP_Y_RESET;
         c_real_ff   <= jet_pkg::C_REAL_RESET;
         c_imag_ff   <= jet_pkg::C_IMAG_RESET;
         limit_ff    <= jet_pkg::LIMIT_RESET;
         imgw_ff     <= jet_pkg::IMGW_RESET;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         step_x_ff   <= step_x_in;
         step_y_ff   <= step_y_in;
         c_real_ff   <= c_real_in;
         c_imag_ff   <= c_imag_in;
         limit_ff    <= limit_in;
         imgw_ff     <= imgw_in;
      end
   end

   // Start point and pixel address
   assign prod_x    = $signed({1'b0, col_ff}) * step_x_ff;
   assign prod_y    = $signed({1'b0, row_ff}) * step_y_ff;
   assign sum_x     = 46'(prod_x) + 46'(origin_x_ff);
   assign sum_y     = 46'(prod_y) + 46'(origin_y_ff);
   assign addr_full = 26'(row_ff) * 26'(imgw_ff) + 26'(col_ff);

   // Shared multiplier, operands picked by the sequencer
   always_comb begin
      case (cmd.mul_sel)
         jet_pkg::MUL_RR: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
         jet_pkg::MUL_II: begin
            mul_a = zi_ff;
            mul_b = zi_ff;
         end
         jet_pkg::MUL_RI: begin
            mul_a = zr_ff;
            mul_b = zi_ff;
         end
         default: begin
            mul_a = zr_ff;
            mul_b = zr_ff;
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // z = z^2 + c, floor shifts back to Q4.28
   assign diff  = rr_ff - ii_ff;
   assign upd_r = 40'(diff >>> jet_pkg::Q_FRAC) + 40'(c_real_ff);
   assign upd_i = 40'(ri_ff >>> (jet_pkg::Q_FRAC - 1)) + 40'(c_imag_ff);

   // Escape test on the squares of the new z
   assign mag = {1'b0, rr_ff[62:0]} + {1'b0, ii_ff[62:0]};

   assign at_limit            = count_ff >= limit_ff;
   assign status.start_in_set = limit_ff <= 16'd1;
   assign status.escaped      = mag > jet_pkg::ESCAPE_Q56;
   assign status.limit_next   = (17'(count_ff) + 17'd1) >= 17'(limit_ff);

   // Working register updates
   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      rr_in    = rr_ff;
      ii_in    = ii_ff;
      ri_in    = ri_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      if (cmd.load_pixel) begin
         col_in = jet_pkg::clamp_dim(pix_column);
         row_in = jet_pkg::clamp_dim(pix_row);
      end
      if (cmd.start) begin
         zr_in    = jet_pkg::sat_q(64'(sum_x));
         zi_in    = jet_pkg::sat_q(64'(sum_y));
         count_in = 16'd1;
         addr_in  = addr_full[23:0];
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            jet_pkg::MUL_RR: rr_in = mul_p;
            jet_pkg::MUL_II: ii_in = mul_p;
            jet_pkg::MUL_RI: ri_in = mul_p;
            default: ;
         endcase
      end
      if (cmd.update) begin
         zr_in = jet_pkg::sat_q(64'(upd_r));
         zi_in = jet_pkg::sat_q(64'(upd_i));
      end
      if (cmd.count_inc) begin
         count_in = count_ff + 16'd1;
      end
   end

   // Result register
   always_comb begin
      res_addr_in   = res_addr_ff;
      res_count_in  = res_count_ff;
      res_in_set_in = res_in_set_ff;
      res_pal_in    = res_pal_ff;
      if (cmd.load_result) begin
         res_addr_in   = addr_ff;
         res_count_in  = count_ff;
         res_in_set_in = at_limit;
         res_pal_in    = at_limit ? 8'd0
                       : 8'(count_ff % 16'(jet_pkg::PALETTE_ENTRIES));
      end
   end

   always_ff @(posedge clock) begin
      col_ff        <= col_in;
      row_ff        <= row_in;
      zr_ff         <= zr_in;
      zi_ff         <= zi_in;
      rr_ff         <= rr_in;
      ii_ff         <= ii_in;
      ri_ff         <= ri_in;
      count_ff      <= count_in;
      addr_ff       <= addr_in;
      res_addr_ff   <= res_addr_in;
      res_count_ff  <= res_count_in;
      res_in_set_ff <= res_in_set_in;
      res_pal_ff    <= res_pal_in;
   end

   assign res_address = res_addr_ff;
   assign res_count   = res_count_ff;
   assign res_in_set  = res_in_set_ff;
   assign res_palette = res_pal_ff;

endmodule

// ----- rtl/jet_ctrl.sv -----
// Controller: iteration sequencer and result handshake
`timescale 1ns / 1ps

module jet_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  jet_pkg::jet_status_type status,
   output jet_pkg::jet_cmd_type    cmd
);

   jet_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jet_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = jet_pkg::ST_START;
         end
         jet_pkg::ST_START: begin
            state_in = status.start_in_set ? jet_pkg::ST_FINISH : jet_pkg::ST_SQR0;
         end
         jet_pkg::ST_SQR0:   state_in = jet_pkg::ST_SQI0;
         jet_pkg::ST_SQI0:   state_in = jet_pkg::ST_CROSS;
         jet_pkg::ST_CROSS:  state_in = jet_pkg::ST_UPDATE;
         jet_pkg::ST_UPDATE: state_in = jet_pkg::ST_SQR;
         jet_pkg::ST_SQR:    state_in = jet_pkg::ST_SQI;
         jet_pkg::ST_SQI:    state_in = jet_pkg::ST_TEST;
         jet_pkg::ST_TEST: begin
            if (status.escaped || status.limit_next) begin
               state_in = jet_pkg::ST_FINISH;
            end else begin
               state_in = jet_pkg::ST_CROSS;
            end
         end
         jet_pkg::ST_FINISH: begin
            if (out_free) state_in = jet_pkg::ST_IDLE;
         end
         default: state_in = jet_pkg::ST_IDLE;
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         jet_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            cmd.load_pixel = req_tvalid;
         end
         jet_pkg::ST_START: cmd.start = 1'b1;
         jet_pkg::ST_SQR0, jet_pkg::ST_SQR: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jet_pkg::MUL_RR;
         end
         jet_pkg::ST_SQI0, jet_pkg::ST_SQI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jet_pkg::MUL_II;
         end
         jet_pkg::ST_CROSS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jet_pkg::MUL_RI;
         end
         jet_pkg::ST_UPDATE: cmd.update = 1'b1;
         jet_pkg::ST_TEST:   cmd.count_inc = !status.escaped;
         jet_pkg::ST_FINISH: cmd.load_result = out_free;
         default: ;
      endcase
   end

   // Result valid flag: set on load, cleared by an output transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jet_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- rtl/julia_escape_time_pixel_core.sv -----
// Sequence: a taken pixel sets up its start point; if the limit is 0 or 1 the sequencer goes
// straight to the finish state, else it squares zr and zi and iterates until escape or the limit.
// Throughput: one pixel at a time, the next taken in the cycle after a result is loaded.
// Each iteration runs zr*zi, update, zr^2, zi^2 and the escape test on the one shared 32x32
// multiplier. A result still held when the next pixel finishes stalls it until taken.
// Reset: synchronous, active high; clears the sequencer and result valid, loads the defaults.
`timescale 1ns / 1ps

module julia_escape_time_pixel_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] column, [23:12] row
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [23:0] pixel_address, [39:24] iteration_count,
                                    // [47:40] palette_index
   output logic        rsp_tuser    // [0] in_set
);

   jet_pkg::jet_cmd_type    cmd;
   jet_pkg::jet_status_type status;
   logic [23:0]             res_address;
   logic [15:0]             res_count;
   logic                    res_in_set;
   logic [7:0]              res_palette;

   // Sequencer
   jet_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Arithmetic and registers
   jet_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pix_column  (req_tdata[11:0]),
      .pix_row     (req_tdata[23:12]),
      .cmd         (cmd),
      .status      (status),
      .res_address (res_address),
      .res_count   (res_count),
      .res_in_set  (res_in_set),
      .res_palette (res_palette)
   );

   assign rsp_tdata = {res_palette, res_count, res_address};
   assign rsp_tuser = res_in_set;

endmodule

// ----- rtl/jet_checker.sv -----
// Port-level checker for the escape-time pixel core, bound to the top level
`timescale 1ns / 1ps
`include "julia_escape_time_pixel_core_macros.svh"

module jet_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A stalled result stays offered and unchanged
   `JET_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "result dropped while stalled")
   `JET_ASSERT_NXT(a_rsp_stable, rsp_tvalid && !rsp_tready, $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // One pixel in flight: intake closes after a transfer
   `JET_ASSERT_NXT(a_one_pixel, req_tvalid && req_tready, !req_tready, "second pixel taken while busy")

   // In-set pixels carry palette index zero
   `JET_ASSERT_IMP(a_inset_pal, rsp_tvalid && rsp_tuser, rsp_tdata[47:40] == 8'd0, "in-set pixel with non-zero palette index")

   // The count never drops below one
   `JET_ASSERT_IMP(a_count_nz, rsp_tvalid, rsp_tdata[39:24] != 16'd0, "zero iteration count")

endmodule

bind julia_escape_time_pixel_core jet_checker u_jet_checker (.*);

// ----- tb/julia_escape_time_pixel_checker.sv -----
// Checker for the escape-time pixel core: predicts each pixel result and compares transfers
`timescale 1ns / 1ps

module julia_escape_time_pixel_checker
   import jet_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // [11:0] column, [23:12] row
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,   // [23:0] pixel_address, [39:24] iteration_count,
                                    // [47:40] palette_index
   input  logic        rsp_tuser,   // [0] in_set
   output int          mismatch_count,
   output int          results_seen,
   output int          in_set_seen,
   output int          expected_left
);

   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;
   localparam int     PRINT_CAP = 40;

   typedef struct packed {
      logic [23:0] addr;
      logic [15:0] count;
      logic        in_set;
      logic [7:0]  palette;
   } pixel_outcome_t;

   // Shadow copy of the register file
   logic signed [31:0] origin_x, origin_y, step_x, step_y, c_real, c_imag;
   logic [15:0]        iter_limit;
   logic [12:0]        img_width;

   pixel_outcome_t expected_pixels[$];
   pixel_outcome_t want;

   initial begin
      mismatch_count = 0;
      results_seen   = 0;
      in_set_seen    = 0;
      expected_left  = 0;
   end

   // Pin a wide value into the signed Q4.28 range
   function automatic longint clip_q(input longint v);
      longint r;
      if (v > Q_MAX) begin
         r = Q_MAX;
      end else if (v < Q_MIN) begin
         r = Q_MIN;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Iterate z = z^2 + c from the pixel's start point until escape or the limit
   function automatic pixel_outcome_t trace_orbit(input logic [11:0] col, input logic [11:0] row);
      pixel_outcome_t r;
      longint         zr, zi, rr, ii, ri;
      logic [63:0]    mag;
      int unsigned    n;
      logic [31:0]    addr_full;
      // a 12-bit index never reaches MAX_DIMENSION, so no clamping is needed here
      zr = clip_q(longint'(origin_x) + longint'(col) * longint'(step_x));
      zi = clip_q(longint'(origin_y) + longint'(row) * longint'(step_y));
      n = 1;
      while (n < iter_limit) begin
         rr = zr * zr;
         ii = zi * zi;
         ri = zr * zi;
         // arithmetic shift of a signed value rounds towards minus infinity
         zr = clip_q(((rr - ii) >>> Q_FRAC) + longint'(c_real));
         zi = clip_q((ri >>> (Q_FRAC - 1)) + longint'(c_imag));
         mag = zr * zr + zi * zi;
         if (mag > ESCAPE_Q56) break;
         n++;
      end
      addr_full = row * img_width + col;
      r.addr    = addr_full[23:0];
      r.count   = n[15:0];
      r.in_set  = (n >= iter_limit);
      r.palette = r.in_set ? 8'd0 : 8'(n % PALETTE_ENTRIES);
      return r;
   endfunction

   task automatic report_fault(input string what, input logic [31:0] got, input logic [31:0] exp_v);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("[%0t] checker: %s got 0x%0h, predicted 0x%0h", $time, what, got, exp_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         origin_x   <= ORIGIN_X_RESET;
         origin_y   <= ORIGIN_Y_RESET;
         step_x     <= STEP_X_RESET;
         step_y     <= STEP_Y_RESET;
         c_real     <= C_REAL_RESET;
         c_imag     <= C_IMAG_RESET;
         iter_limit <= LIMIT_RESET;
         img_width  <= IMGW_RESET;
         expected_pixels.delete();
      end else begin
         // register writes
         if (csr_we) begin
            case (csr_index)
               CSR_ORIGIN_X:    origin_x   <= csr_wdata;
               CSR_ORIGIN_Y:    origin_y   <= csr_wdata;
               CSR_STEP_X:      step_x     <= csr_wdata;
               CSR_STEP_Y:      step_y     <= csr_wdata;
               CSR_C_REAL:      c_real     <= csr_wdata;
               CSR_C_IMAG:      c_imag     <= csr_wdata;
               CSR_ITER_LIMIT:  iter_limit <= csr_wdata[15:0];
               CSR_IMAGE_WIDTH: img_width  <= csr_wdata[12:0];
               default: ;
            endcase
         end

         // result transfer: compare against the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (rsp_tuser) in_set_seen <= in_set_seen + 1;
            if (expected_pixels.size() == 0) begin
               report_fault("result with no pixel outstanding", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_tdata[23:0] !== want.addr)
                  report_fault("pixel_address", rsp_tdata[23:0], want.addr);
               if (rsp_tdata[39:24] !== want.count)
                  report_fault("iteration_count", rsp_tdata[39:24], want.count);
               if (rsp_tdata[47:40] !== want.palette)
                  report_fault("palette_index", rsp_tdata[47:40], want.palette);
               if (rsp_tuser !== want.in_set)
                  report_fault("in_set", rsp_tuser, want.in_set);
            end
         end

         // pixel transfer: predict with the settings in force now
         if (req_tvalid && req_tready) begin
            expected_pixels.push_back(trace_orbit(req_tdata[11:0], req_tdata[23:12]));
         end
      end
      expected_left <= expected_pixels.size();
   end

endmodule

// ----- tb/julia_escape_time_pixel_core_tb.sv -----
// Testbench top for the escape-time pixel core: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module julia_escape_time_pixel_core_tb;
   import jet_pkg::*;

   localparam int     RANDOM_SETTINGS  = 14;
   localparam int     PIXELS_PER_SET   = 125;
   localparam int     DRAIN_CYCLES     = 40;
   localparam longint CYCLE_LIMIT      = 8000000;

   typedef enum logic [1:0] {
      DRAIN_FREE,
      DRAIN_HALF,
      DRAIN_LIGHT,
      DRAIN_HEAVY
   } drain_mode_e;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // [11:0] column, [23:12] row
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;   // [23:0] pixel_address, [39:24] iteration_count,
                             // [47:40] palette_index
   logic        rsp_tuser;   // [0] in_set

   int mismatch_count, results_seen, in_set_seen, expected_left;
   int items_sent     = 0;
   int settings_used  = 0;
   longint cycle_count = 0;

   drain_mode_e drain_mode = DRAIN_FREE;
   int          drain_left = 0;

   julia_escape_time_pixel_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   julia_escape_time_pixel_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_seen   (results_seen),
      .in_set_seen    (in_set_seen),
      .expected_left  (expected_left)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results still owed",
                  cycle_count, items_sent - results_seen);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result side back-pressure: a new random stall pattern each time the countdown runs out
   always @(posedge clock) begin
      if (drain_left == 0) begin
         drain_mode <= drain_mode_e'($urandom_range(0, 3));
         drain_left <= $urandom_range(20, 300);
      end else begin
         drain_left <= drain_left - 1;
      end
      case (drain_mode)
         DRAIN_FREE:  rsp_tready <= 1'b1;
         DRAIN_HALF:  rsp_tready <= ($urandom_range(0, 1) == 1);
         DRAIN_LIGHT: rsp_tready <= ($urandom_range(0, 7) != 0);
         default:     rsp_tready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   // One pixel transfer; valid is left high for a following pixel
   task automatic send_pixel(input logic [11:0] col, input logic [11:0] row);
      req_tvalid <= 1'b1;
      req_tdata  <= {row, col};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Stop sending and wait until every pixel has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // Reprogram the whole register file once the core has gone quiet
   task automatic load_view(input logic [31:0] ox, input logic [31:0] oy,
                            input logic [31:0] sx, input logic [31:0] sy,
                            input logic [31:0] cr, input logic [31:0] ci,
                            input logic [31:0] lim, input logic [31:0] w);
      settle();
      write_reg(CSR_ORIGIN_X, ox);
      write_reg(CSR_ORIGIN_Y, oy);
      write_reg(CSR_STEP_X, sx);
      write_reg(CSR_STEP_Y, sy);
      write_reg(CSR_C_REAL, cr);
      write_reg(CSR_C_IMAG, ci);
      write_reg(CSR_ITER_LIMIT, lim);
      write_reg(CSR_IMAGE_WIDTH, w);
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // Random pixels in bursts of random length with random gaps
   task automatic run_random(input int n);
      int          left, burst, gap;
      logic [11:0] col, row;
      left = n;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > left) burst = left;
         repeat (burst) begin
            col = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                               : 12'($urandom_range(0, 4095));
            row = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 12'hFFF : 12'h000)
                                               : 12'($urandom_range(0, 4095));
            send_pixel(col, row);
            left--;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      int ox, oy, sx, sy, cr, ci, lim, w;

      reset      <= 1'b1;
      csr_we     <= 1'b0;
      csr_index  <= CSR_ORIGIN_X;
      csr_wdata  <= 32'd0;
      req_tvalid <= 1'b0;
      req_tdata  <= 24'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: corners, alternating bits, and the centre index
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'hFFF, 12'd0);
      send_pixel(12'd0, 12'hFFF);
      send_pixel(12'd2048, 12'd2048);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);

      // Limit of zero, then of one: no iteration at all; widths of zero and far too wide
      load_view(ORIGIN_X_RESET, ORIGIN_Y_RESET, STEP_X_RESET, STEP_Y_RESET,
                C_REAL_RESET, C_IMAG_RESET, 32'd0, 32'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd1, 12'd2);
      load_view(ORIGIN_X_RESET, ORIGIN_Y_RESET, STEP_X_RESET, STEP_Y_RESET,
                C_REAL_RESET, C_IMAG_RESET, 32'd1, 32'd8191);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd7, 12'd3);

      // Start point saturates in both directions, so every pixel escapes at once
      load_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h8000_0000, 32'h7FFF_FFFF, 32'd65535, 32'd4096);
      send_pixel(12'd0, 12'd0);
      send_pixel(12'hFFF, 12'hFFF);
      send_pixel(12'd1, 12'd0);

      // Magnitude exactly 4.0 counts as inside: c = 2.0 escapes on the second test
      load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'h2000_0000, 32'd0, 32'd10, 32'd1);
      send_pixel(12'd5, 12'd9);
      // c = -2.0 settles on z = 2.0 and sits on the boundary up to the limit
      load_view(32'd0, 32'd0, 32'd0, 32'd0, 32'hE000_0000, 32'd0, 32'd10, 32'd1);
      send_pixel(12'd0, 12'd0);
      // Start near 8.0: the first square saturates inside the update
      load_view(32'h7F00_0000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd10, 32'd4095);
      send_pixel(12'd3, 12'd0);

      // Random settings: mostly a window over the interesting region, some wild
      for (int p = 0; p < RANDOM_SETTINGS; p++) begin
         if (p % 5 == 4) begin
            ox  = $urandom();
            oy  = $urandom();
            sx  = $urandom();
            sy  = $urandom();
            cr  = $urandom();
            ci  = $urandom();
            lim = $urandom_range(0, 40);
            w   = $urandom_range(0, 8191);
         end else begin
            sx = $urandom_range(16384, 524288);
            if ($urandom_range(0, 1)) sx = -sx;
            sy = $urandom_range(16384, 524288);
            if ($urandom_range(0, 1)) sy = -sy;
            // centre the grid on the origin with a little jitter
            ox = -sx * 2048 + int'($urandom_range(0, 1 << 27)) - (1 << 26);
            oy = -sy * 2048 + int'($urandom_range(0, 1 << 27)) - (1 << 26);
            cr = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            ci = int'($urandom_range(0, 1 << 29)) - (1 << 28);
            if (p == 7) begin
               lim = $urandom_range(100, 160);
            end else if ($urandom_range(0, 9) == 0) begin
               lim = $urandom_range(0, 1);
            end else begin
               lim = $urandom_range(2, 40);
            end
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 4096);
         end
         load_view(ox, oy, sx, sy, cr, ci, lim, w);
         run_random(PIXELS_PER_SET);
      end

      // Drain and give the verdict
      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Swept %0d pixels over %0d register settings; %0d results compared",
               items_sent, settings_used + 1, results_seen);
      $display("%0d pixels came back in the set, %0d escaped",
               in_set_seen, results_seen - in_set_seen);
      if (mismatch_count == 0 && expected_left == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
